### design/fdc_pkg.sv
`timescale 1ns / 1ps

package fdc_pkg;

  // Field widths.
  localparam int OP_W     = 3;
  localparam int IDX_W    = 3;
  localparam int DUTY_IN_W = 8;
  localparam int KIND_W   = 2;
  localparam int CH_W     = 3;
  localparam int CMP_W    = 17;
  localparam int DUTY_W   = 7;
  localparam int PSC_W    = 10;
  localparam int TOP_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 26;

  // Shared divider width and its iteration counter.
  localparam int DIV_W    = 26;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Product duty * (top + 1) width.
  localparam int PROD_W   = DUTY_W + TOP_W + 1;

  // Channels per timer and fan units.
  localparam int CHANNELS = 4;
  localparam int UNITS    = 4;
  localparam int SEL_W    = 2;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_SET_POWER   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_REMOTE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_UNIT    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_POWER  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_REMOTE = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUS_CLOCK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_FREQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_FREQ = 2'd2;

  // Reset and default values.
  localparam logic [CFG_W-1:0] BUS_CLOCK_RESET = 26'd48000000;
  localparam logic [PSC_W-1:0] PSC_DEFAULT     = '0;
  localparam logic [TOP_W-1:0] TOP_DEFAULT     = 16'hFFFF;
  localparam logic [DIV_W-1:0] TICKS_LIMIT     = 26'd65536;
  localparam logic [DUTY_W-1:0] DUTY_MAX       = 7'd100;
  localparam logic [DIV_W-1:0] PCT_DIVISOR     = 26'd100;

  // Fan unit link table: power channel and remote channel of each unit.
  localparam logic [CH_W-1:0] UNIT_POWER_CH  [UNITS] = '{3'd2, 3'd1, 3'd4, 3'd3};
  localparam logic [CH_W-1:0] UNIT_REMOTE_CH [UNITS] = '{3'd1, 3'd4, 3'd3, 3'd2};

endpackage

### design/fdc_if.sv
`timescale 1ns / 1ps

// Request channel.
interface fdc_req_if import fdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [IDX_W-1:0]     index;
  logic [DUTY_IN_W-1:0] duty;

  modport source (output valid, output op, output index, output duty, input ready);
  modport sink   (input valid, input op, input index, input duty, output ready);
endinterface

// Result channel.
interface fdc_rsp_if import fdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              timer_sel;
  logic [CH_W-1:0]   channel;
  logic [CMP_W-1:0]  compare;
  logic [DUTY_W-1:0] duty_level;
  logic [PSC_W-1:0]  prescaler;
  logic [TOP_W-1:0]  period_top;
  logic              last;

  modport source (output valid, output kind, output timer_sel, output channel,
                  output compare, output duty_level, output prescaler,
                  output period_top, output last, input ready);
  modport sink   (input valid, input kind, input timer_sel, input channel,
                  input compare, input duty_level, input prescaler,
                  input period_top, input last, output ready);
endinterface

// Configuration write channel.
interface fdc_cfg_if import fdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/fdc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module fdc_div import fdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvsr;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       rem_sub;
  logic                 fits;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr};
    fits    = (rem_sh >= {1'b0, dvsr});
  end

  // Step control; done pulses for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

### design/dual_pwm_fan_duty_controller.sv
`timescale 1ns / 1ps

// Channel  Role      Handshake     Payload
// req      sink      valid/ready   op, index, duty
// rsp      source    valid/ready   kind, timer_sel, channel, compare, duty_level,
//                                  prescaler, period_top, last
// cfg      sink      valid/ready   index, data
//
// A set result is computed in the shared 26-step divider, which divides duty * (top + 1)
// by 100; a unit request gives two results. Reads and rejected requests skip the divider.
// A configuration write recomputes both timers through the same divider, with neither
// req nor cfg ready. Reset (rst, synchronous) restores the state, configuration, timer and
// duty registers to their defaults and clears out_valid; payload registers are not reset.
// A stalled result holds rsp; the next request is taken while it waits.

module dual_pwm_fan_duty_controller import fdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  fdc_req_if.sink   req,
  fdc_rsp_if.source rsp,
  fdc_cfg_if.sink   cfg
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_HALF   = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_DIVW   = 8'b0000_1000,
    S_EMIT   = 8'b0001_0000,
    S_TSTART = 8'b0010_0000,
    S_TICKW  = 8'b0100_0000,
    S_TOPW   = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration and timing registers.
  logic [CFG_W-1:0] bus_clock_hz;
  logic [CFG_W-1:0] power_freq_hz;
  logic [CFG_W-1:0] remote_freq_hz;
  logic [PSC_W-1:0] power_psc;
  logic [TOP_W-1:0] power_top;
  logic [PSC_W-1:0] remote_psc;
  logic [TOP_W-1:0] remote_top;
  logic             tmr;

  // Duty stores.
  logic [DUTY_W-1:0] power_duty  [CHANNELS];
  logic [DUTY_W-1:0] remote_duty [CHANNELS];

  // Request registers.
  logic [OP_W-1:0]   req_op;
  logic [IDX_W-1:0]  req_idx;
  logic [DUTY_W-1:0] req_duty;
  logic              half;

  // Current result under work.
  logic [KIND_W-1:0] cur_kind;
  logic              cur_tsel;
  logic [CH_W-1:0]   cur_ch;
  logic              cur_last;
  logic              cur_set;
  logic [DUTY_W-1:0] cur_duty;
  logic [CMP_W-1:0]  cur_cmp;
  logic [PROD_W-1:0] prod;

  // Output register.
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic              out_tsel;
  logic [CH_W-1:0]   out_ch;
  logic [CMP_W-1:0]  out_cmp;
  logic [DUTY_W-1:0] out_duty;
  logic [PSC_W-1:0]  out_psc;
  logic [TOP_W-1:0]  out_top;
  logic              out_last;

  // Divider connections.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  fdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Handshakes.
  logic req_fire, cfg_fire, out_free;
  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Decode of the current half of a request.
  logic [KIND_W-1:0] h_kind_raw, h_kind;
  logic              h_tsel, h_last, h_ok, h_set;
  logic [CH_W-1:0]   h_ch_raw, h_ch;
  logic [DUTY_W-1:0] h_duty;
  logic [SEL_W-1:0]  unit_sel, ch_sel;
  logic              unit_ok;

  always_comb begin
    unit_sel   = SEL_W'(req_idx - 3'd1);
    unit_ok    = (req_idx >= 3'd1) && (req_idx <= 3'(UNITS));
    h_kind_raw = KIND_REJECT;
    h_tsel     = 1'b0;
    h_ch_raw   = '0;
    h_last     = 1'b1;
    case (req_op)
      OP_SET_POWER: begin
        h_kind_raw = KIND_UPDATE;
        h_ch_raw   = req_idx;
      end
      OP_SET_REMOTE: begin
        h_kind_raw = KIND_UPDATE;
        h_tsel     = 1'b1;
        h_ch_raw   = req_idx;
      end
      OP_SET_UNIT: begin
        if (unit_ok) begin
          h_kind_raw = KIND_UPDATE;
          h_tsel     = half;
          h_ch_raw   = half ? UNIT_REMOTE_CH[unit_sel] : UNIT_POWER_CH[unit_sel];
          h_last     = half;
        end
      end
      OP_READ_POWER: begin
        h_kind_raw = KIND_READ;
        h_ch_raw   = req_idx;
      end
      OP_READ_REMOTE: begin
        h_kind_raw = KIND_READ;
        h_tsel     = 1'b1;
        h_ch_raw   = req_idx;
      end
      default: begin
        h_kind_raw = KIND_REJECT;
      end
    endcase

    h_ok   = (h_ch_raw >= 3'd1) && (h_ch_raw <= 3'(CHANNELS));
    ch_sel = SEL_W'(h_ch_raw - 3'd1);
    h_set  = (h_kind_raw == KIND_UPDATE) && h_ok;
    h_kind = ((h_kind_raw == KIND_UPDATE) && !h_ok) ? KIND_REJECT : h_kind_raw;
    h_ch   = ((h_kind_raw != KIND_REJECT) && h_ok) ? h_ch_raw : '0;
    if (h_set) begin
      h_duty = req_duty;
    end else if ((h_kind_raw == KIND_READ) && h_ok) begin
      h_duty = h_tsel ? remote_duty[ch_sel] : power_duty[ch_sel];
    end else begin
      h_duty = '0;
    end
  end

  // Timer derivation helpers.
  logic [CFG_W-1:0] cur_freq;
  logic             ticks_big;
  assign cur_freq  = tmr ? remote_freq_hz : power_freq_hz;
  assign ticks_big = (div_q > TICKS_LIMIT);

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {(DIV_W - PROD_W)'(0), prod};
    div_divisor  = PCT_DIVISOR;
    unique case (state)
      S_MUL: begin
        div_start = 1'b1;
      end
      S_TSTART: begin
        div_start    = (cur_freq != '0);
        div_dividend = bus_clock_hz;
        div_divisor  = cur_freq;
      end
      S_TICKW: begin
        div_start    = div_done && ticks_big;
        div_dividend = div_q;
        div_divisor  = {(DIV_W - PSC_W)'(0), div_q[DIV_W-1 -: PSC_W]} + 26'd1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tmr            <= 1'b0;
      half           <= 1'b0;
      out_valid      <= 1'b0;
      bus_clock_hz   <= BUS_CLOCK_RESET;
      power_freq_hz  <= '0;
      remote_freq_hz <= '0;
      power_psc      <= PSC_DEFAULT;
      power_top      <= TOP_DEFAULT;
      remote_psc     <= PSC_DEFAULT;
      remote_top     <= TOP_DEFAULT;
      for (int i = 0; i < CHANNELS; i++) begin
        power_duty[i]  <= '0;
        remote_duty[i] <= '0;
      end
    end else begin
      // A result leaves on its transfer unless a new one is loaded in its place.
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            case (cfg.index)
              REG_BUS_CLOCK: begin
                bus_clock_hz <= cfg.data;
                tmr          <= 1'b0;
                state        <= S_TSTART;
              end
              REG_POWER_FREQ: begin
                power_freq_hz <= cfg.data;
                tmr           <= 1'b0;
                state         <= S_TSTART;
              end
              REG_REMOTE_FREQ: begin
                remote_freq_hz <= cfg.data;
                tmr            <= 1'b0;
                state          <= S_TSTART;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end else if (req_fire) begin
            half  <= 1'b0;
            state <= S_HALF;
          end
        end
        S_HALF: begin
          state <= h_set ? S_MUL : S_EMIT;
        end
        S_MUL: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (cur_set) begin
              if (cur_tsel) begin
                remote_duty[SEL_W'(cur_ch - 3'd1)] <= cur_duty;
              end else begin
                power_duty[SEL_W'(cur_ch - 3'd1)] <= cur_duty;
              end
            end
            if (cur_last) begin
              state <= S_IDLE;
            end else begin
              half  <= 1'b1;
              state <= S_HALF;
            end
          end
        end
        S_TSTART: begin
          if (cur_freq == '0) begin
            if (tmr) begin
              remote_psc <= PSC_DEFAULT;
              remote_top <= TOP_DEFAULT;
              state      <= S_IDLE;
            end else begin
              power_psc <= PSC_DEFAULT;
              power_top <= TOP_DEFAULT;
              tmr       <= 1'b1;
            end
          end else begin
            state <= S_TICKW;
          end
        end
        S_TICKW: begin
          if (div_done) begin
            if (ticks_big) begin
              // Prescaled range: the top comes from a second division.
              if (tmr) begin
                remote_psc <= div_q[DIV_W-1 -: PSC_W];
              end else begin
                power_psc <= div_q[DIV_W-1 -: PSC_W];
              end
              state <= S_TOPW;
            end else begin
              if (tmr) begin
                remote_psc <= PSC_DEFAULT;
                remote_top <= (div_q != '0) ? div_q[TOP_W-1:0] - 16'd1 : TOP_DEFAULT;
              end else begin
                power_psc <= PSC_DEFAULT;
                power_top <= (div_q != '0) ? div_q[TOP_W-1:0] - 16'd1 : TOP_DEFAULT;
              end
              if (tmr) begin
                state <= S_IDLE;
              end else begin
                tmr   <= 1'b1;
                state <= S_TSTART;
              end
            end
          end
        end
        S_TOPW: begin
          if (div_done) begin
            if (tmr) begin
              remote_top <= div_q[TOP_W-1:0] - 16'd1;
              state      <= S_IDLE;
            end else begin
              power_top <= div_q[TOP_W-1:0] - 16'd1;
              tmr       <= 1'b1;
              state     <= S_TSTART;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and per-result working registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_op   <= req.op;
      req_idx  <= req.index;
      req_duty <= (req.duty > {1'b0, DUTY_MAX}) ? DUTY_MAX : req.duty[DUTY_W-1:0];
    end
    if (state == S_HALF) begin
      cur_kind <= h_kind;
      cur_tsel <= h_tsel;
      cur_ch   <= h_ch;
      cur_last <= h_last;
      cur_set  <= h_set;
      cur_duty <= h_duty;
      cur_cmp  <= '0;
    end
    if (state == S_MUL) begin
      cur_cmp <= '0;
    end
    if ((state == S_DIVW) && div_done) begin
      cur_cmp <= div_q[CMP_W-1:0];
    end
  end

  // Product register ahead of the divider.
  always_ff @(posedge clk) begin
    if (state == S_HALF) begin
      prod <= PROD_W'(h_duty) * PROD_W'(h_tsel ? {1'b0, remote_top} + 17'd1
                                               : {1'b0, power_top} + 17'd1);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_kind <= cur_kind;
      out_tsel <= cur_tsel;
      out_ch   <= cur_ch;
      out_cmp  <= cur_cmp;
      out_duty <= cur_duty;
      out_psc  <= cur_tsel ? remote_psc : power_psc;
      out_top  <= cur_tsel ? remote_top : power_top;
      out_last <= cur_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.timer_sel  = out_tsel;
  assign rsp.channel    = out_ch;
  assign rsp.compare    = out_cmp;
  assign rsp.duty_level = out_duty;
  assign rsp.prescaler  = out_psc;
  assign rsp.period_top = out_top;
  assign rsp.last       = out_last;

endmodule
